// ===== rtl/scsc_pkg.sv =====
// Shared types, constants and tables for the serial command stepper controller.
package scsc_pkg;

    localparam int LINE_LEN_DEF = 8;
    localparam int KW_COUNT     = 6;
    localparam int KW_MAX_LEN   = 7;
    localparam int CFG_W        = 14;
    localparam int MAG_W        = 14;
    localparam int PHASES_W     = 16;

    localparam logic [CFG_W-1:0] MAX_STEPS_RST = 14'd8192;
    localparam logic [CFG_W-1:0] HARD_LIMIT    = 14'd8192;
    localparam logic [MAG_W-1:0] MAG_SAT       = 14'd16383;

    typedef enum logic [3:0] {
        MSG_NONE     = 4'd0,
        MSG_EN_CAT   = 4'd1,
        MSG_EN_ION   = 4'd2,
        MSG_DIS_CAT  = 4'd3,
        MSG_DIS_ION  = 4'd4,
        MSG_EN_BOTH  = 4'd5,
        MSG_DIS_BOTH = 4'd6,
        MSG_OPEN     = 4'd7,
        MSG_CLOSE    = 4'd8,
        MSG_DONE     = 4'd9,
        MSG_BAD      = 4'd10,
        MSG_BUSY     = 4'd11
    } msg_t;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Keyword text, padded with NUL past each keyword's length.
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"E", "n", "C", "a", "t", 8'h00, 8'h00},
        '{"E", "n", "I", "o", "n", 8'h00, 8'h00},
        '{"D", "i", "s", "C", "a", "t", 8'h00},
        '{"D", "i", "s", "I", "o", "n", 8'h00},
        '{"E", "n", "B", "o", "t", "h", 8'h00},
        '{"D", "i", "s", "B", "o", "t", "h"}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd7};
    localparam msg_t KW_ACK [KW_COUNT] = '{
        MSG_EN_CAT, MSG_EN_ION, MSG_DIS_CAT, MSG_DIS_ION, MSG_EN_BOTH, MSG_DIS_BOTH
    };

    // Full-step coil sequence for a phase index and direction.
    function automatic logic [3:0] pattern_at(input logic ccw, input logic [1:0] idx);
        logic [3:0] pat;
        unique case (idx)
            2'd0: pat = ccw ? 4'h9 : 4'hC;
            2'd1: pat = ccw ? 4'h3 : 4'h6;
            2'd2: pat = ccw ? 4'h6 : 4'h3;
            default: pat = ccw ? 4'hC : 4'h9;
        endcase
        return pat;
    endfunction

endpackage

// ===== rtl/serial_command_stepper_controller.sv =====
// Serial command stepper controller: line parser, keyword decoder and stepper sequencer.
// Path: the input beat is held in the input register, and its result is registered in the result register.
// Throughput: 1 beat per cycle while out_stall is low; one pass through the parse and step logic, one result per beat.
// Reset: rst_n (asynchronous, active low) empties the line, stops the motor,
//   turns all coils and enable lines off and loads max_steps with 8192.
module serial_command_stepper_controller
    import scsc_pkg::*;
#(
    parameter int LINE_LEN = LINE_LEN_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             cfg_write_en,
    input  logic [CFG_W-1:0] cfg_write_data,
    // input channel
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             action,
    input  logic [7:0]       rx_byte,
    // result channel
    output logic             out_valid,
    input  logic             out_stall,
    output logic [3:0]       coil_pattern,
    output logic             cathode_on,
    output logic             ionizer_on,
    output logic             pulse_on,
    output logic [3:0]       message,
    output logic             busy_res
);

    // Character count must hold LINE_LEN itself.
    localparam int CNT_W = $clog2(LINE_LEN + 1);
    localparam logic [CNT_W-1:0] LINE_FULL = CNT_W'(LINE_LEN);

    typedef enum logic [1:0] {
        NUM_SKIP,    // skipping leading whitespace
        NUM_SIGN,    // sign seen, no digit yet
        NUM_DIGITS,  // accumulating digits
        NUM_DEAD     // number ended, later characters ignored
    } num_phase_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   max_steps_reg;

    logic               in_valid_reg;
    logic               action_reg;
    logic [7:0]         byte_reg;

    logic               out_valid_reg;
    msg_t               msg_reg;

    logic [CNT_W-1:0]   char_count_reg,   char_count_next;
    logic [KW_COUNT-1:0] kw_alive_reg,    kw_alive_next;
    num_phase_t         num_phase_reg,    num_phase_next;
    logic               num_neg_reg,      num_neg_next;
    logic [MAG_W-1:0]   num_mag_reg,      num_mag_next;
    logic [PHASES_W-1:0] phases_left_reg, phases_left_next;
    logic               turn_ccw_reg,     turn_ccw_next;
    logic [1:0]         phase_idx_reg,    phase_idx_next;
    logic [3:0]         coils_reg,        coils_next;
    logic [2:0]         enables_reg,      enables_next;
    msg_t               msg_next;

    // ------------------------------------------------------------------
    // Handshake: a held input beat is processed when the result register
    // is empty or its beat is being taken this cycle.
    // ------------------------------------------------------------------
    logic proc;
    logic in_take;

    assign proc     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Parse and step logic for the beat in the input register
    // ------------------------------------------------------------------
    logic              is_digit;
    logic              is_space;
    logic [3:0]        digit_val;
    logic [MAG_W+3:0]  mag_acc;
    logic [CFG_W-1:0]  limit;
    logic              kw_hit;
    logic [CNT_W-1:0]  pos;

    assign is_digit  = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
    assign is_space  = (byte_reg == CH_SP) || (byte_reg == CH_TAB) ||
                       (byte_reg == CH_VT) || (byte_reg == CH_FF);
    assign digit_val = 4'(byte_reg - CH_ZERO);
    // mag * 10 + digit as shift-and-add
    assign mag_acc   = {1'b0, num_mag_reg, 3'b000} + {3'b000, num_mag_reg, 1'b0} +
                       (MAG_W+4)'(digit_val);
    assign limit     = (max_steps_reg > HARD_LIMIT) ? HARD_LIMIT : max_steps_reg;
    assign pos       = char_count_reg;

    always_comb
    begin
        char_count_next  = char_count_reg;
        kw_alive_next    = kw_alive_reg;
        num_phase_next   = num_phase_reg;
        num_neg_next     = num_neg_reg;
        num_mag_next     = num_mag_reg;
        phases_left_next = phases_left_reg;
        turn_ccw_next    = turn_ccw_reg;
        phase_idx_next   = phase_idx_reg;
        coils_next       = coils_reg;
        enables_next     = enables_reg;
        msg_next         = MSG_NONE;
        kw_hit           = 1'b0;

        if (action_reg) begin
            // Phase tick: advance the coils while motion remains.
            if (phases_left_reg != '0) begin
                phase_idx_next   = phase_idx_reg + 2'd1;
                coils_next       = pattern_at(turn_ccw_reg, phase_idx_reg + 2'd1);
                phases_left_next = phases_left_reg - PHASES_W'(1);
                if (phases_left_reg == PHASES_W'(1)) begin
                    msg_next = MSG_DONE;
                end
            end
        end else if (phases_left_reg != '0) begin
            // Drop the byte while the motor runs.
            msg_next = MSG_BUSY;
        end else if (byte_reg == CH_NL) begin
            // Execute the line: first live keyword of full length wins.
            for (int k = 0; k < KW_COUNT; k++) begin
                if (!kw_hit && kw_alive_reg[k] &&
                    (char_count_reg == CNT_W'(KW_LEN[k]))) begin
                    kw_hit   = 1'b1;
                    msg_next = KW_ACK[k];
                    unique case (KW_ACK[k])
                        MSG_EN_CAT:  enables_next = enables_reg | 3'b001;
                        MSG_EN_ION:  enables_next = enables_reg | 3'b010;
                        MSG_DIS_CAT: enables_next = enables_reg & 3'b110;
                        MSG_DIS_ION: enables_next = enables_reg & 3'b101;
                        MSG_EN_BOTH: enables_next = 3'b111;
                        default:     enables_next = 3'b000;
                    endcase
                end
            end
            if (!kw_hit) begin
                if ((num_mag_reg != '0) && ({1'b0, num_mag_reg} <= {1'b0, limit})) begin
                    turn_ccw_next    = num_neg_reg;
                    phase_idx_next   = 2'd0;
                    phases_left_next = {num_mag_reg, 2'b00};
                    coils_next       = pattern_at(num_neg_reg, 2'd0);
                    msg_next         = num_neg_reg ? MSG_OPEN : MSG_CLOSE;
                end else begin
                    msg_next = MSG_BAD;
                end
            end
            // Start a fresh line.
            char_count_next = '0;
            kw_alive_next   = '1;
            num_phase_next  = NUM_SKIP;
            num_neg_next    = 1'b0;
            num_mag_next    = '0;
        end else if (byte_reg != CH_CR) begin
            if (char_count_reg >= LINE_FULL) begin
                // Overrun: drop the byte and restart the line empty.
                char_count_next = '0;
                kw_alive_next   = '1;
                num_phase_next  = NUM_SKIP;
                num_neg_next    = 1'b0;
                num_mag_next    = '0;
            end else begin
                // Narrow each keyword match by this character.
                for (int k = 0; k < KW_COUNT; k++) begin
                    if ((pos >= CNT_W'(KW_LEN[k])) ||
                        (KW_TEXT[k][pos[2:0]] != byte_reg)) begin
                        kw_alive_next[k] = 1'b0;
                    end
                end
                char_count_next = char_count_reg + CNT_W'(1);
                unique case (num_phase_reg)
                    NUM_SKIP:
                    begin
                        if (is_space) begin
                            num_phase_next = NUM_SKIP;
                        end else if ((byte_reg == CH_PLUS) || (byte_reg == CH_MINUS)) begin
                            num_neg_next   = (byte_reg == CH_MINUS);
                            num_phase_next = NUM_SIGN;
                        end else if (is_digit) begin
                            num_mag_next   = MAG_W'(digit_val);
                            num_phase_next = NUM_DIGITS;
                        end else begin
                            num_phase_next = NUM_DEAD;
                        end
                    end
                    NUM_SIGN, NUM_DIGITS:
                    begin
                        if (is_digit) begin
                            // Saturate the magnitude.
                            num_mag_next   = (mag_acc > (MAG_W+4)'(MAG_SAT)) ?
                                             MAG_SAT : mag_acc[MAG_W-1:0];
                            num_phase_next = NUM_DIGITS;
                        end else begin
                            num_phase_next = NUM_DEAD;
                        end
                    end
                    default:
                    begin
                        num_phase_next = NUM_DEAD;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // State, input register and result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_steps_reg   <= MAX_STEPS_RST;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            msg_reg         <= MSG_NONE;
            char_count_reg  <= '0;
            kw_alive_reg    <= '1;
            num_phase_reg   <= NUM_SKIP;
            num_neg_reg     <= 1'b0;
            num_mag_reg     <= '0;
            phases_left_reg <= '0;
            turn_ccw_reg    <= 1'b0;
            phase_idx_reg   <= 2'd0;
            coils_reg       <= 4'h0;
            enables_reg     <= 3'b000;
        end else begin
            if (cfg_write_en) begin
                max_steps_reg <= cfg_write_data;
            end

            // Hold the input beat until it is processed.
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (proc) begin
                in_valid_reg <= 1'b0;
            end

            if (proc) begin
                out_valid_reg   <= 1'b1;
                msg_reg         <= msg_next;
                char_count_reg  <= char_count_next;
                kw_alive_reg    <= kw_alive_next;
                num_phase_reg   <= num_phase_next;
                num_neg_reg     <= num_neg_next;
                num_mag_reg     <= num_mag_next;
                phases_left_reg <= phases_left_next;
                turn_ccw_reg    <= turn_ccw_next;
                phase_idx_reg   <= phase_idx_next;
                coils_reg       <= coils_next;
                enables_reg     <= enables_next;
            end else if (out_valid_reg && !out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the input beat needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            action_reg <= action;
            byte_reg   <= rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Result beat. Line state only moves when a result is loaded, so the
    // state registers stay put while a result waits.
    // ------------------------------------------------------------------
    assign out_valid    = out_valid_reg;
    assign coil_pattern = coils_reg;
    assign cathode_on   = enables_reg[0];
    assign ionizer_on   = enables_reg[1];
    assign pulse_on     = enables_reg[2];
    assign message      = msg_reg;
    assign busy_res     = (phases_left_reg != '0);

endmodule
